FILE: src/c2e_pkg.sv
`timescale 1ns / 1ps

package c2e_pkg;

	// micro-rotations per pass, clamped to the arctangent table
	localparam int ANGLE_ITERATIONS = 16;
	localparam int TABLE_LEN        = 24;
	localparam int N_CELLS          = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN
	                                                                 : ANGLE_ITERATIONS;
	localparam int IDX_W            = $clog2(TABLE_LEN);

	// vector legs: input lsb scaled by 2^16, headroom for two cordic gains
	localparam int LEG_W = 40;
	// angles in 2^-32 turn, signed, covering the half-turn start plus the table sum
	localparam int ANG_W = 34;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 16;
	localparam int GUARD_BITS = 16;
	localparam int GAIN_W  = 32;
	localparam int PROD_W  = COORD_W + GAIN_W;
	// product is y * K * 2^30, legs want y * K * 2^16
	localparam int GAIN_SHIFT = 30 - GUARD_BITS;

	// cordic gain in q30
	localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 32'sd1768195363;

	localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sd2147483648);
	localparam logic signed [ANG_W:0]   QUARTER_TURN = (ANG_W+1)'(64'sd1073741824);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [LEG_W-1:0] leg_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	// payload carried from cell to cell
	typedef struct packed {
		leg_t              a;
		leg_t              b;
		ang_t              ang;
		logic              skip;
		leg_t              yk;
		logic [FRAC_W-1:0] u;
	} cell_data_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input idx_t idx);
		logic [31:0] r;
		case (idx)
			idx_t'(0):  r = 32'd536870912;
			idx_t'(1):  r = 32'd316933406;
			idx_t'(2):  r = 32'd167458907;
			idx_t'(3):  r = 32'd85004756;
			idx_t'(4):  r = 32'd42667331;
			idx_t'(5):  r = 32'd21354465;
			idx_t'(6):  r = 32'd10679838;
			idx_t'(7):  r = 32'd5340245;
			idx_t'(8):  r = 32'd2670163;
			idx_t'(9):  r = 32'd1335087;
			idx_t'(10): r = 32'd667544;
			idx_t'(11): r = 32'd333772;
			idx_t'(12): r = 32'd166886;
			idx_t'(13): r = 32'd83443;
			idx_t'(14): r = 32'd41722;
			idx_t'(15): r = 32'd20861;
			idx_t'(16): r = 32'd10430;
			idx_t'(17): r = 32'd5215;
			idx_t'(18): r = 32'd2608;
			idx_t'(19): r = 32'd1304;
			idx_t'(20): r = 32'd652;
			idx_t'(21): r = 32'd326;
			idx_t'(22): r = 32'd163;
			idx_t'(23): r = 32'd81;
			default:    r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: src/c2e_ifs.sv
`timescale 1ns / 1ps

// direction channel
interface c2e_dir_if;
	logic                                valid;
	logic                                ready;
	logic signed [c2e_pkg::COORD_W-1:0]  coord_x;
	logic signed [c2e_pkg::COORD_W-1:0]  coord_y;
	logic signed [c2e_pkg::COORD_W-1:0]  coord_z;

	modport source (output valid, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// panorama coordinate channel
interface c2e_uv_if;
	logic                         valid;
	logic                         ready;
	logic [c2e_pkg::FRAC_W-1:0]   u_frac;
	logic [c2e_pkg::FRAC_W-1:0]   v_frac;

	modport source (output valid, u_frac, v_frac, input ready);
	modport sink (input valid, u_frac, v_frac, output ready);
endinterface

FILE: src/c2e_prep.sv
`timescale 1ns / 1ps

module c2e_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [c2e_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [c2e_pkg::COORD_W-1:0]  coord_y,
	input  logic signed [c2e_pkg::COORD_W-1:0]  coord_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output c2e_pkg::cell_data_t                 out_data
);

	logic                                 valid_q;
	c2e_pkg::cell_data_t                  data_q;
	c2e_pkg::cell_data_t                  nxt;
	c2e_pkg::leg_t                        ax;
	c2e_pkg::leg_t                        bz;
	logic signed [c2e_pkg::PROD_W-1:0]    prod;

	// scale to leg format, fold negative x into the right half plane
	always_comb begin
		ax   = {{(c2e_pkg::LEG_W-c2e_pkg::COORD_W-c2e_pkg::GUARD_BITS){coord_x[c2e_pkg::COORD_W-1]}},
		        coord_x, {c2e_pkg::GUARD_BITS{1'b0}}};
		bz   = {{(c2e_pkg::LEG_W-c2e_pkg::COORD_W-c2e_pkg::GUARD_BITS){coord_z[c2e_pkg::COORD_W-1]}},
		        coord_z, {c2e_pkg::GUARD_BITS{1'b0}}};
		prod = coord_y * c2e_pkg::GAIN_Q30;
		nxt  = '0;
		if (coord_x[c2e_pkg::COORD_W-1]) begin
			nxt.a   = -ax;
			nxt.b   = -bz;
			nxt.ang = c2e_pkg::HALF_TURN;
		end else begin
			nxt.a   = ax;
			nxt.b   = bz;
			nxt.ang = '0;
		end
		nxt.skip = (coord_x == '0) && (coord_z == '0);
		// y at cordic gain, floor division via arithmetic shift
		nxt.yk   = c2e_pkg::leg_t'(prod >>> c2e_pkg::GAIN_SHIFT);
		nxt.u    = '0;
	end

	assign in_ready = !valid_q || out_ready;

	// stage handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: src/c2e_cell.sv
`timescale 1ns / 1ps

module c2e_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c2e_pkg::idx_t        idx,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2e_pkg::cell_data_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2e_pkg::cell_data_t  out_data
);

	logic                 valid_q;
	c2e_pkg::cell_data_t  data_q;
	c2e_pkg::cell_data_t  nxt;
	c2e_pkg::leg_t        da;
	c2e_pkg::leg_t        db;
	c2e_pkg::ang_t        step;

	// one vectoring micro-rotation
	always_comb begin
		da   = in_data.a >>> idx;
		db   = in_data.b >>> idx;
		step = $signed({{(c2e_pkg::ANG_W-32){1'b0}}, c2e_pkg::atan_turn(idx)});
		nxt  = in_data;
		if (!in_data.b[c2e_pkg::LEG_W-1]) begin
			nxt.a   = in_data.a + db;
			nxt.b   = in_data.b - da;
			nxt.ang = in_data.skip ? in_data.ang : in_data.ang + step;
		end else begin
			nxt.a   = in_data.a - db;
			nxt.b   = in_data.b + da;
			nxt.ang = in_data.skip ? in_data.ang : in_data.ang - step;
		end
	end

	assign in_ready = !valid_q || out_ready;

	// stage handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: src/c2e_join.sv
`timescale 1ns / 1ps

module c2e_join (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c2e_pkg::cell_data_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output c2e_pkg::cell_data_t  out_data
);

	logic                 valid_q;
	c2e_pkg::cell_data_t  data_q;
	c2e_pkg::cell_data_t  nxt;
	logic [31:0]          u32;
	logic [32:0]          u_rnd;

	// round longitude to u, set up the latitude pass on (magnitude, y*K)
	always_comb begin
		u32      = in_data.ang[31:0] + 32'h8000_0000;
		u_rnd    = {1'b0, u32} + 33'h0_0000_8000;
		nxt      = in_data;
		nxt.a    = in_data.a;
		nxt.b    = in_data.yk;
		nxt.ang  = '0;
		nxt.skip = (in_data.a == '0) && (in_data.yk == '0);
		nxt.u    = u_rnd[31:16];
	end

	assign in_ready = !valid_q || out_ready;

	// stage handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

FILE: src/c2e_round.sv
`timescale 1ns / 1ps

module c2e_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  c2e_pkg::cell_data_t         in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [c2e_pkg::FRAC_W-1:0]  u_frac,
	output logic [c2e_pkg::FRAC_W-1:0]  v_frac
);

	logic                            valid_q;
	logic [c2e_pkg::FRAC_W-1:0]      u_q;
	logic [c2e_pkg::FRAC_W-1:0]      v_q;
	logic [c2e_pkg::FRAC_W-1:0]      v_nxt;
	logic signed [c2e_pkg::ANG_W:0]  vv;
	logic signed [c2e_pkg::ANG_W:0]  vr;
	logic [c2e_pkg::ANG_W-15:0]      vq;

	// latitude plus quarter turn, round to a half-turn fraction, clamp
	always_comb begin
		vv = $signed({in_data.ang[c2e_pkg::ANG_W-1], in_data.ang}) + c2e_pkg::QUARTER_TURN;
		vr = vv + (c2e_pkg::ANG_W+1)'(16'h4000);
		vq = vr[c2e_pkg::ANG_W:15];
		if (vv[c2e_pkg::ANG_W]) begin
			v_nxt = '0;
		end else if (|vq[c2e_pkg::ANG_W-15:c2e_pkg::FRAC_W]) begin
			v_nxt = '1;
		end else begin
			v_nxt = vq[c2e_pkg::FRAC_W-1:0];
		end
	end

	assign in_ready = !valid_q || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			u_q <= in_data.u;
			v_q <= v_nxt;
		end
	end

	assign out_valid = valid_q;
	assign u_frac    = u_q;
	assign v_frac    = v_q;

endmodule

FILE: src/cartesian_to_equirect_uv.sv
`timescale 1ns / 1ps

// Equirectangular projection of a 3-D direction.
// Input channel dir carries coord_x, coord_y, coord_z (signed 16-bit, same scale);
// output channel uv carries u_frac (longitude, fraction of a full turn, wraps)
// and v_frac (latitude from the south pole, fraction of a half turn, saturates).
// Each accepted transaction gives exactly one result transaction, in order.
// Structure: an input stage (half-plane fold, y times the cordic gain), a row of
// cordic cells for atan2(z, x), a join stage that rounds u and starts the
// latitude pass, a second row of cells for atan2(y, r), and the output register.
// One cell per micro-rotation, 16 per row by default.
// One transaction per cycle is taken and delivered when the receiver
// keeps ready high.
// When the receiver stalls, the result holds in the output register and the
// cells behind it keep advancing until each holds a transaction, so empty
// slots in the rows are filled before dir.ready drops.
// Reset clears all valid flags; no results are pending afterwards.
module cartesian_to_equirect_uv (
	input  logic  clk,
	input  logic  arst_n,
	c2e_dir_if.sink   dir,
	c2e_uv_if.source  uv
);

	logic [c2e_pkg::N_CELLS:0]  p1_valid;
	logic [c2e_pkg::N_CELLS:0]  p1_ready;
	c2e_pkg::cell_data_t        p1_data [c2e_pkg::N_CELLS+1];
	logic [c2e_pkg::N_CELLS:0]  p2_valid;
	logic [c2e_pkg::N_CELLS:0]  p2_ready;
	c2e_pkg::cell_data_t        p2_data [c2e_pkg::N_CELLS+1];

	// input stage
	c2e_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dir.valid),
		.in_ready  (dir.ready),
		.coord_x   (dir.coord_x),
		.coord_y   (dir.coord_y),
		.coord_z   (dir.coord_z),
		.out_valid (p1_valid[0]),
		.out_ready (p1_ready[0]),
		.out_data  (p1_data[0])
	);

	// longitude row
	for (genvar i = 0; i < c2e_pkg::N_CELLS; i++) begin : g_lon
		c2e_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (c2e_pkg::idx_t'(i)),
			.in_valid  (p1_valid[i]),
			.in_ready  (p1_ready[i]),
			.in_data   (p1_data[i]),
			.out_valid (p1_valid[i+1]),
			.out_ready (p1_ready[i+1]),
			.out_data  (p1_data[i+1])
		);
	end

	// u rounding and latitude setup
	c2e_join u_join (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p1_valid[c2e_pkg::N_CELLS]),
		.in_ready  (p1_ready[c2e_pkg::N_CELLS]),
		.in_data   (p1_data[c2e_pkg::N_CELLS]),
		.out_valid (p2_valid[0]),
		.out_ready (p2_ready[0]),
		.out_data  (p2_data[0])
	);

	// latitude row
	for (genvar i = 0; i < c2e_pkg::N_CELLS; i++) begin : g_lat
		c2e_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (c2e_pkg::idx_t'(i)),
			.in_valid  (p2_valid[i]),
			.in_ready  (p2_ready[i]),
			.in_data   (p2_data[i]),
			.out_valid (p2_valid[i+1]),
			.out_ready (p2_ready[i+1]),
			.out_data  (p2_data[i+1])
		);
	end

	// v rounding and output register
	c2e_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p2_valid[c2e_pkg::N_CELLS]),
		.in_ready  (p2_ready[c2e_pkg::N_CELLS]),
		.in_data   (p2_data[c2e_pkg::N_CELLS]),
		.out_valid (uv.valid),
		.out_ready (uv.ready),
		.u_frac    (uv.u_frac),
		.v_frac    (uv.v_frac)
	);

endmodule

FILE: test/cartesian_to_equirect_uv_tb.sv
`timescale 1ns / 1ps

module cartesian_to_equirect_uv_tb;

	localparam int CLK_HALF_NS = 6;
	localparam int RESET_CYCLES = 6;
	localparam int PIPE_LATENCY = 2 * c2e_pkg::N_CELLS + 3;
	localparam int ATAN_LEN = 24;
	localparam longint TURN_HALF = 64'sd2147483648;
	localparam longint TURN_QUARTER = 64'sd1073741824;
	localparam longint LEG_SCALE = 64'sd65536;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam longint ATAN_STEP [0:ATAN_LEN-1] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};

	typedef logic signed [c2e_pkg::COORD_W-1:0] coord_t;
	typedef logic [c2e_pkg::FRAC_W-1:0] frac_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		frac_t  u;
		frac_t  v;
	} panorama_uv_t;

	logic clk;
	logic arst_n;

	c2e_dir_if dir_ch ();
	c2e_uv_if  uv_ch ();

	cartesian_to_equirect_uv dut (
		.clk    (clk),
		.arst_n (arst_n),
		.dir    (dir_ch),
		.uv     (uv_ch)
	);

	panorama_uv_t pending_uv [$];
	int           mismatch_count = 0;
	bit           sender_gaps = 1'b1;
	bit           receiver_stalls = 1'b1;

	// clock
	always begin
		clk = 1'b1;
		#(CLK_HALF_NS);
		clk = 1'b0;
		#(CLK_HALF_NS);
	end

	// run limit
	initial begin
		#(10_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	// one cordic vectoring pass, shifts round toward minus infinity
	function automatic void vector_rotate(inout longint a, inout longint b, inout longint ang);
		longint da;
		longint db;
		int     n;
		n = (c2e_pkg::ANGLE_ITERATIONS > ATAN_LEN) ? ATAN_LEN : c2e_pkg::ANGLE_ITERATIONS;
		for (int i = 0; i < n; i++) begin
			da = a >>> i;
			db = b >>> i;
			if (b >= 0) begin
				a   = a + db;
				b   = b - da;
				ang = ang + ATAN_STEP[i];
			end else begin
				a   = a - db;
				b   = b + da;
				ang = ang - ATAN_STEP[i];
			end
		end
	endfunction

	// expected panorama coordinates of one direction
	function automatic panorama_uv_t project_dir(coord_t x, coord_t y, coord_t z);
		panorama_uv_t e;
		longint a;
		longint b;
		longint lon;
		longint lat;
		longint yk;
		longint vv;
		longint u32;
		longint v_raw;
		e.x = x;
		e.y = y;
		e.z = z;
		a   = longint'(x) * LEG_SCALE;
		b   = longint'(z) * LEG_SCALE;
		lon = 0;
		lat = 0;
		// longitude pass, left half-plane folded by half a turn
		if (a != 0 || b != 0) begin
			if (a < 0) begin
				a   = -a;
				b   = -b;
				lon = TURN_HALF;
			end
			vector_rotate(a, b, lon);
		end
		u32 = (lon + TURN_HALF) & 64'sh0000_0000_FFFF_FFFF;
		e.u = frac_t'((u32 + 64'sd32768) >>> 16);
		// latitude pass on (r*K, y*K)
		yk = (longint'(y) * longint'(c2e_pkg::GAIN_Q30)) >>> c2e_pkg::GAIN_SHIFT;
		if (a != 0 || yk != 0)
			vector_rotate(a, yk, lat);
		vv = lat + TURN_QUARTER;
		if (vv < 0) begin
			e.v = '0;
		end else begin
			v_raw = (vv + 64'sd16384) >>> 15;
			e.v = (v_raw > 65535) ? 16'hFFFF : frac_t'(v_raw);
		end
		return e;
	endfunction

	// scoreboard: compare results first, then record new transactions
	always @(posedge clk) begin
		panorama_uv_t e;
		if (arst_n) begin
			if (uv_ch.valid && uv_ch.ready) begin
				if (pending_uv.size() == 0) begin
					$display("%0t: unexpected result u_frac %0d v_frac %0d", $time,
						uv_ch.u_frac, uv_ch.v_frac);
					mismatch_count++;
				end else begin
					e = pending_uv.pop_front();
					if (uv_ch.u_frac !== e.u) begin
						$display("%0t: u_frac for (%0d,%0d,%0d) expected %0d actual %0d",
							$time, e.x, e.y, e.z, e.u, uv_ch.u_frac);
						mismatch_count++;
					end
					if (uv_ch.v_frac !== e.v) begin
						$display("%0t: v_frac for (%0d,%0d,%0d) expected %0d actual %0d",
							$time, e.x, e.y, e.z, e.v, uv_ch.v_frac);
						mismatch_count++;
					end
				end
			end
			if (dir_ch.valid && dir_ch.ready)
				pending_uv.push_back(project_dir(dir_ch.coord_x, dir_ch.coord_y, dir_ch.coord_z));
		end
	end

	// receiver: random stall bursts
	initial begin
		uv_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				uv_ch.ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			uv_ch.ready = 1'b1;
		end
	end

	// send one direction, called and returning at a falling edge
	task automatic send_dir(coord_t x, coord_t y, coord_t z);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			dir_ch.valid   = 1'b0;
			dir_ch.coord_x = coord_t'($urandom);
			dir_ch.coord_y = coord_t'($urandom);
			dir_ch.coord_z = coord_t'($urandom);
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		dir_ch.valid   = 1'b1;
		dir_ch.coord_x = x;
		dir_ch.coord_y = y;
		dir_ch.coord_z = z;
		do
			@(posedge clk);
		while (!dir_ch.ready);
		@(negedge clk);
	endtask

	// axes, poles, zero vector, full-scale corners and the longitude wrap
	task automatic test_axes_and_poles();
		send_dir(16'sd0, 16'sd0, 16'sd0);
		send_dir(16'sd32767, 16'sd0, 16'sd0);
		send_dir(-16'sd32768, 16'sd0, 16'sd0);
		send_dir(16'sd0, 16'sd0, 16'sd32767);
		send_dir(16'sd0, 16'sd0, -16'sd32768);
		send_dir(16'sd0, 16'sd32767, 16'sd0);
		send_dir(16'sd0, -16'sd32768, 16'sd0);
		send_dir(16'sd0, 16'sd1, 16'sd0);
		send_dir(16'sd0, -16'sd1, 16'sd0);
		send_dir(-16'sd1, 16'sd0, 16'sd0);
		send_dir(16'sd1, 16'sd0, 16'sd0);
		send_dir(16'sd0, 16'sd0, 16'sd1);
		send_dir(-16'sd32768, 16'sd0, -16'sd1);
		send_dir(-16'sd32768, 16'sd0, 16'sd1);
		send_dir(-16'sd32768, -16'sd32768, -16'sd32768);
		send_dir(16'sd32767, 16'sd32767, 16'sd32767);
		send_dir(-16'sd32768, 16'sd32767, -16'sd32768);
		send_dir(16'sd32767, -16'sd32768, 16'sd32767);
		send_dir(16'sd1, 16'sd1, 16'sd1);
		send_dir(-16'sd1, -16'sd1, -16'sd1);
		send_dir(16'sd0, 16'sd32767, 16'sd1);
		send_dir(-16'sd1, 16'sd32767, 16'sd0);
	endtask

	// random directions: full range, tiny vectors, axis planes, near-extremes
	task automatic test_random_directions(int count);
		coord_t picks [6] = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		coord_t x;
		coord_t y;
		coord_t z;
		for (int n = 0; n < count; n++) begin
			x = coord_t'($urandom);
			y = coord_t'($urandom);
			z = coord_t'($urandom);
			case ($urandom_range(0, 9))
				5, 6: begin
					x = coord_t'(int'($urandom_range(0, 16)) - 8);
					y = coord_t'(int'($urandom_range(0, 16)) - 8);
					z = coord_t'(int'($urandom_range(0, 16)) - 8);
				end
				7: begin
					if ($urandom_range(0, 1))
						x = '0;
					else
						z = '0;
				end
				8: begin
					x = '0;
					z = '0;
				end
				9: begin
					x = picks[$urandom_range(0, 5)];
					y = picks[$urandom_range(0, 5)];
					z = picks[$urandom_range(0, 5)];
				end
				default: ;
			endcase
			send_dir(x, y, z);
		end
	endtask

	// full-rate stream, no gaps and no stalls
	task automatic test_full_rate(int count);
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		for (int n = 0; n < count; n++)
			send_dir(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
	endtask

	initial begin
		arst_n         = 1'b0;
		dir_ch.valid   = 1'b0;
		dir_ch.coord_x = '0;
		dir_ch.coord_y = '0;
		dir_ch.coord_z = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_axes_and_poles();
		test_random_directions(930);
		test_full_rate(100);
		dir_ch.valid = 1'b0;

		// drain
		while (pending_uv.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
